### design/olws_pkg.sv
`timescale 1ns / 1ps

package olws_pkg;

    localparam int DEPTH_DEF = 1024;

    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 10;
    localparam int STATUS_W = 2;
    localparam int FPOS_W   = 10;
    localparam int ECNT_W   = 11;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SEARCH
    } t_state;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_APPEND,
        DP_FULL,
        DP_MISS,
        DP_RM_ISSUE,
        DP_RD_ISSUE,
        DP_RD_DONE,
        DP_SRCH_INIT,
        DP_SRCH_STEP,
        DP_FOUND
    } t_dp_op;

    typedef struct packed {
        logic   latch;
        t_dp_op op;
    } t_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic full;
        logic empty;
        logic pos_ok;
        logic match;
        logic last;
        logic out_free;
    } t_sts;

endpackage

### design/ordered_list_with_search.sv
`timescale 1ns / 1ps
// channel   handshake                    payload
// input     i_in_valid / o_in_ready      i_cmd, i_value, i_position
// output    o_out_valid / i_out_ready    o_status, o_data_out, o_found_position, o_entry_count
//
// append and a command refused at dispatch finish in the execute state
// remove and read go on through one registered read of the storage
// find scans from position 0 and stops at the first match or after the last entry,
// one entry compared per cycle through the single read port
// reset clears the entry count and the output valid; stored entries need no clearing
// a new transaction is accepted while a result waits; execution holds until it is taken

module ordered_list_with_search #(
    parameter int DEPTH = olws_pkg::DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [olws_pkg::CMD_W-1:0]            i_cmd,
    input  logic signed [olws_pkg::VALUE_W-1:0]   i_value,
    input  logic [olws_pkg::POS_W-1:0]            i_position,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [olws_pkg::STATUS_W-1:0]         o_status,
    output logic signed [olws_pkg::VALUE_W-1:0]   o_data_out,
    output logic [olws_pkg::FPOS_W-1:0]           o_found_position,
    output logic [olws_pkg::ECNT_W-1:0]           o_entry_count
);
    import olws_pkg::*;

    t_ctl ctl;
    t_sts sts;

    olws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    olws_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .o_sts            (sts),
        .i_cmd            (i_cmd),
        .i_value          (i_value),
        .i_position       (i_position),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_data_out       (o_data_out),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count)
    );

endmodule

### design/olws_ctrl.sv
`timescale 1ns / 1ps

module olws_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  olws_pkg::t_sts i_sts,
    output olws_pkg::t_ctl o_ctl
);
    import olws_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    unique case (i_sts.cmd)
                        CMD_APPEND: n_state = S_IDLE;
                        CMD_REMOVE: n_state = i_sts.empty ? S_IDLE : S_READ;
                        CMD_FIND:   n_state = i_sts.empty ? S_IDLE : S_SEARCH;
                        CMD_READ:   n_state = i_sts.pos_ok ? S_READ : S_IDLE;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_READ: begin
                n_state = S_IDLE;
            end
            S_SEARCH: begin
                if (i_sts.match || i_sts.last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_ctl.latch = 1'b0;
        o_ctl.op    = DP_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctl.latch = i_in_valid;
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    unique case (i_sts.cmd)
                        CMD_APPEND: o_ctl.op = i_sts.full ? DP_FULL : DP_APPEND;
                        CMD_REMOVE: o_ctl.op = i_sts.empty ? DP_MISS : DP_RM_ISSUE;
                        CMD_FIND:   o_ctl.op = i_sts.empty ? DP_MISS : DP_SRCH_INIT;
                        CMD_READ:   o_ctl.op = i_sts.pos_ok ? DP_RD_ISSUE : DP_MISS;
                        default:    o_ctl.op = DP_NONE;
                    endcase
                end
            end
            S_READ: begin
                o_ctl.op = DP_RD_DONE;
            end
            S_SEARCH: begin
                priority if (i_sts.match) begin
                    o_ctl.op = DP_FOUND;
                end else if (i_sts.last) begin
                    o_ctl.op = DP_MISS;
                end else begin
                    o_ctl.op = DP_SRCH_STEP;
                end
            end
            default: o_ctl.op = DP_NONE;
        endcase
    end

endmodule

### design/olws_dp.sv
`timescale 1ns / 1ps

module olws_dp #(
    parameter int DEPTH = olws_pkg::DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  olws_pkg::t_ctl                        i_ctl,
    output olws_pkg::t_sts                        o_sts,
    input  logic [olws_pkg::CMD_W-1:0]            i_cmd,
    input  logic signed [olws_pkg::VALUE_W-1:0]   i_value,
    input  logic [olws_pkg::POS_W-1:0]            i_position,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [olws_pkg::STATUS_W-1:0]         o_status,
    output logic signed [olws_pkg::VALUE_W-1:0]   o_data_out,
    output logic [olws_pkg::FPOS_W-1:0]           o_found_position,
    output logic [olws_pkg::ECNT_W-1:0]           o_entry_count
);
    import olws_pkg::*;

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int PW   = (CW > POS_W) ? CW : POS_W;
    localparam int FPW  = (AW > FPOS_W) ? AW : FPOS_W;
    localparam int ECW  = (CW > ECNT_W) ? CW : ECNT_W;

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rdata;

    t_cmd               r_cmd;
    logic [VALUE_W-1:0] r_value;
    logic [POS_W-1:0]   r_pos;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    logic [AW-1:0]      r_cmp_idx;
    logic               r_cmp_vld;
    logic               r_out_valid;
    t_status            r_status;
    logic [VALUE_W-1:0] r_data;
    logic [FPW-1:0]     r_fpos;
    logic [ECW-1:0]     r_ecount;

    logic [CW-1:0]      n_count;
    logic [CW-1:0]      n_idx;
    logic               n_cmp_vld;
    logic               out_load;
    t_status            n_status;
    logic [VALUE_W-1:0] n_data;
    logic [FPW-1:0]     n_fpos;
    logic               wr_en;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [CW-1:0]      cnt_dec;
    logic               out_free;

    assign cnt_dec  = r_count - CW'(1);
    assign out_free = !r_out_valid || i_out_ready;

    assign o_sts.cmd      = r_cmd;
    assign o_sts.full     = (r_count >= CW'(DEPTH));
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.pos_ok   = (PW'(r_pos) < PW'(r_count));
    assign o_sts.match    = r_cmp_vld && (r_rdata == r_value);
    assign o_sts.last     = r_cmp_vld && ((CW'(r_cmp_idx) + CW'(1)) == r_count);
    assign o_sts.out_free = out_free;

    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_cmp_vld = r_cmp_vld;
        out_load  = 1'b0;
        n_status  = ST_OK;
        n_data    = '0;
        n_fpos    = '0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = r_count[AW-1:0];
        unique case (i_ctl.op)
            DP_NONE: begin
            end
            DP_APPEND: begin
                wr_en    = 1'b1;
                n_count  = r_count + CW'(1);
                out_load = 1'b1;
            end
            DP_FULL: begin
                out_load = 1'b1;
                n_status = ST_FULL;
            end
            DP_MISS: begin
                out_load = 1'b1;
                n_status = ST_MISS;
            end
            DP_RM_ISSUE: begin
                n_count = cnt_dec;
                rd_en   = 1'b1;
                rd_addr = cnt_dec[AW-1:0];
            end
            DP_RD_ISSUE: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_pos);
            end
            DP_RD_DONE: begin
                out_load = 1'b1;
                n_data   = r_rdata;
            end
            DP_SRCH_INIT: begin
                n_idx     = '0;
                n_cmp_vld = 1'b0;
            end
            DP_SRCH_STEP: begin
                rd_en     = 1'b1;
                rd_addr   = r_idx[AW-1:0];
                n_cmp_vld = (r_idx < r_count);
                n_idx     = r_idx + CW'(1);
            end
            DP_FOUND: begin
                out_load = 1'b1;
                n_fpos   = FPW'(r_cmp_idx);
            end
            default: begin
            end
        endcase
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[AW-1:0]] <= r_value;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_value <= i_value;
            r_pos   <= i_position;
        end
        r_idx <= n_idx;
        if (i_ctl.op == DP_SRCH_STEP) begin
            r_cmp_idx <= r_idx[AW-1:0];
        end
        if (out_load) begin
            r_status <= n_status;
            r_data   <= n_data;
            r_fpos   <= n_fpos;
            r_ecount <= ECW'(n_count);
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_data_out       = r_data;
    assign o_found_position = r_fpos[FPOS_W-1:0];
    assign o_entry_count    = r_ecount[ECNT_W-1:0];

endmodule

### test/tb_ordered_list_with_search.sv
`timescale 1ns / 1ps

module tb_ordered_list_with_search;

    import olws_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_AFTER     = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 20;

    typedef struct {
        t_cmd                        cmd;
        logic signed [VALUE_W-1:0]   value;
        logic [POS_W-1:0]            position;
    } t_list_cmd;

    typedef struct {
        t_status                     status;
        logic signed [VALUE_W-1:0]   data;
        logic [FPOS_W-1:0]           fpos;
        logic [ECNT_W-1:0]           cnt;
    } t_list_reply;

    typedef enum {
        RX_FREE,
        RX_HALF,
        RX_SLOW,
        RX_BUSY
    } t_rx_mode;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic [CMD_W-1:0]            i_cmd = '0;
    logic signed [VALUE_W-1:0]   i_value = '0;
    logic [POS_W-1:0]            i_position = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic [STATUS_W-1:0]         o_status;
    logic signed [VALUE_W-1:0]   o_data_out;
    logic [FPOS_W-1:0]           o_found_position;
    logic [ECNT_W-1:0]           o_entry_count;

    // predictor state
    logic signed [VALUE_W-1:0]   list_mem [0:DEPTH-1];
    int                          list_cnt = 0;

    t_list_cmd                   cmds_to_send [$];
    t_list_reply                 replies_due [$];
    logic signed [VALUE_W-1:0]   gen_vals [$];

    t_list_cmd                   next_cmd;
    t_list_reply                 want;
    int                          burst_left = 0;
    int                          gap_left = 0;
    int                          results_seen = 0;
    int                          hold_left = 0;
    bit                          hold_done = 1'b0;
    t_rx_mode                    rx_mode = RX_FREE;
    int                          rx_mode_left = 0;
    int                          idle_cycles = 0;
    int                          err_cnt = 0;

    ordered_list_with_search #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_value          (i_value),
        .i_position       (i_position),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_data_out       (o_data_out),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_list_reply apply_list_cmd(t_cmd cmd, logic signed [VALUE_W-1:0] value,
                                                   logic [POS_W-1:0] position);
        t_list_reply r;
        r.status = ST_OK;
        r.data   = '0;
        r.fpos   = '0;
        case (cmd)
            CMD_APPEND: begin
                if (list_cnt >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_mem[list_cnt] = value;
                    list_cnt++;
                end
            end
            CMD_REMOVE: begin
                if (list_cnt == 0) begin
                    r.status = ST_MISS;
                end else begin
                    list_cnt--;
                    r.data = list_mem[list_cnt];
                end
            end
            CMD_FIND: begin
                r.status = ST_MISS;
                for (int i = 0; i < list_cnt; i++) begin
                    if (list_mem[i] == value) begin
                        r.status = ST_OK;
                        r.fpos   = FPOS_W'(i);
                        break;
                    end
                end
            end
            default: begin
                if (int'(position) < list_cnt) begin
                    r.data = list_mem[position];
                end else begin
                    r.status = ST_MISS;
                end
            end
        endcase
        r.cnt = ECNT_W'(list_cnt);
        return r;
    endfunction

    // stimulus side keeps its own view of the list to aim finds and reads
    task automatic queue_cmd(t_cmd c, logic signed [VALUE_W-1:0] v, logic [POS_W-1:0] p);
        t_list_cmd it;
        it.cmd      = c;
        it.value    = v;
        it.position = p;
        cmds_to_send.push_back(it);
        if (c == CMD_APPEND && gen_vals.size() < DEPTH) begin
            gen_vals.push_back(v);
        end else if (c == CMD_REMOVE && gen_vals.size() > 0) begin
            void'(gen_vals.pop_back());
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0, 1: begin
                if (gen_vals.size() > 0) begin
                    return gen_vals[$urandom_range(0, gen_vals.size() - 1)];
                end
                return $urandom;
            end
            2: return $signed($urandom_range(0, 16)) - 32'sd8;
            3: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int sz = gen_vals.size();
        case ($urandom_range(0, 9))
            0, 1: return POS_W'($urandom);
            2: return POS_W'(sz);
            default: return (sz > 0) ? POS_W'($urandom_range(0, sz - 1)) : POS_W'($urandom);
        endcase
    endfunction

    task automatic queue_mixed(int pct_append, int pct_remove, int pct_find);
        int r = $urandom_range(0, 99);
        t_cmd c;
        if (r < pct_append) begin
            c = CMD_APPEND;
        end else if (r < pct_append + pct_remove) begin
            c = CMD_REMOVE;
        end else if (r < pct_append + pct_remove + pct_find) begin
            c = CMD_FIND;
        end else begin
            c = CMD_READ;
        end
        queue_cmd(c, pick_value(), pick_position());
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (cmds_to_send.size() != 0 || i_in_valid || replies_due.size() != 0);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                replies_due.push_back(apply_list_cmd(t_cmd'(i_cmd), i_value, i_position));
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (cmds_to_send.size() > 0) begin
                    next_cmd = cmds_to_send.pop_front();
                    i_in_valid <= 1'b1;
                    i_cmd      <= next_cmd.cmd;
                    i_value    <= next_cmd.value;
                    i_position <= next_cmd.position;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (replies_due.size() == 0) begin
                    $display("%0t unexpected transaction: status %0d data %0d fpos %0d count %0d",
                             $time, o_status, o_data_out, o_found_position, o_entry_count);
                    err_cnt++;
                end else begin
                    want = replies_due.pop_front();
                    if (o_status !== want.status) begin
                        $display("%0t status expected %0d actual %0d",
                                 $time, want.status, o_status);
                        err_cnt++;
                    end
                    if (o_data_out !== want.data) begin
                        $display("%0t data_out expected %0d actual %0d",
                                 $time, want.data, o_data_out);
                        err_cnt++;
                    end
                    if (o_found_position !== want.fpos) begin
                        $display("%0t found_position expected %0d actual %0d",
                                 $time, want.fpos, o_found_position);
                        err_cnt++;
                    end
                    if (o_entry_count !== want.cnt) begin
                        $display("%0t entry_count expected %0d actual %0d",
                                 $time, want.cnt, o_entry_count);
                        err_cnt++;
                    end
                end
            end
            // one long hold-off so the input side backs up
            if (results_seen >= HOLD_AFTER && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode      = t_rx_mode'($urandom_range(0, 3));
                    rx_mode_left = $urandom_range(20, 200);
                end
                rx_mode_left--;
                case (rx_mode)
                    RX_FREE: i_out_ready <= 1'b1;
                    RX_HALF: i_out_ready <= 1'($urandom_range(0, 1));
                    RX_SLOW: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default: i_out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t no transaction for %0d cycles", $time, idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list corner cases
        queue_cmd(CMD_REMOVE, $urandom, POS_W'($urandom));
        queue_cmd(CMD_FIND, 32'sd0, '0);
        queue_cmd(CMD_READ, $urandom, '0);
        // extremes and duplicates
        queue_cmd(CMD_APPEND, 32'sh80000000, '0);
        queue_cmd(CMD_APPEND, 32'sh7fffffff, '1);
        queue_cmd(CMD_APPEND, 32'sd0, '0);
        queue_cmd(CMD_APPEND, -32'sd1, '0);
        queue_cmd(CMD_APPEND, 32'sd5, '0);
        queue_cmd(CMD_APPEND, 32'sd5, '1);
        queue_cmd(CMD_FIND, 32'sd5, '1);
        queue_cmd(CMD_FIND, 32'sh80000000, '0);
        queue_cmd(CMD_FIND, -32'sd1, '0);
        queue_cmd(CMD_FIND, 32'sh7fffffff, '0);
        queue_cmd(CMD_FIND, 32'sd12345, '0);
        queue_cmd(CMD_READ, 32'sd0, 10'd0);
        queue_cmd(CMD_READ, '1, 10'd5);
        queue_cmd(CMD_READ, 32'sd0, 10'd6);
        queue_cmd(CMD_READ, 32'sd0, '1);
        queue_cmd(CMD_REMOVE, 32'sd0, '0);
        queue_cmd(CMD_REMOVE, '1, '1);
        queue_cmd(CMD_FIND, 32'sd5, '0);
        queue_cmd(CMD_READ, 32'sd0, 10'd3);
        wait_drained();

        // mixed traffic at low fill
        repeat (60) queue_mixed(35, 30, 15);
        wait_drained();

        // fill up to the top
        while (gen_vals.size() < DEPTH) queue_mixed(93, 2, 3);
        queue_cmd(CMD_APPEND, $urandom, POS_W'($urandom));
        queue_cmd(CMD_APPEND, 32'sh7fffffff, '1);
        queue_cmd(CMD_READ, $urandom, '1);
        queue_cmd(CMD_READ, $urandom, '0);
        queue_cmd(CMD_FIND, gen_vals[DEPTH-1], '0);
        queue_cmd(CMD_FIND, $urandom, '0);
        queue_cmd(CMD_REMOVE, $urandom, '0);
        queue_cmd(CMD_READ, $urandom, '1);
        queue_cmd(CMD_APPEND, 32'sh80000000, '0);
        queue_cmd(CMD_APPEND, $urandom, '0);
        repeat (10) queue_mixed(40, 10, 25);
        wait_drained();

        // drain
        repeat (60) queue_mixed(15, 55, 15);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (replies_due.size() != 0) begin
            $display("%0t %0d expected transactions never arrived", $time, replies_due.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
